>>> rtl/lru_key_value_cache_defines.svh
// ============================================================================
// LRU key/value cache assertion macros
// Shared concurrent assertion forms for the cache checker.
// ============================================================================
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LKV_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lkv assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LKV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lkv assertion failed");

`endif

>>> rtl/lkv_pkg.sv
// ============================================================================
// LRU key/value cache package
// Payload types, command and status groups and fixed constants.
// ============================================================================
`default_nettype none

package lkv_pkg;

	// Operation codes
	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;

	// Configuration port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic [0:0] REG_CAPACITY = 1'b0;

	// Capacity register
	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// Value returned on a get miss
	localparam logic signed [31:0] VALUE_MISS = -32'sd1;

	typedef struct packed {
		logic               cmd;
		logic signed [31:0] key_in;
		logic signed [31:0] value_in;
	} req_t;

	typedef struct packed {
		logic               found;
		logic signed [31:0] value_out;
		logic               evicted;
		logic signed [31:0] evicted_key;
	} rsp_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic scan;
		logic commit;
	} ctl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic scan_done;
		logic out_busy;
	} ctl_sts_t;

endpackage

`default_nettype wire

>>> rtl/lkv_stream_if.sv
// ============================================================================
// LRU key/value cache stream channel
// Valid/ready channel carrying one payload beat.
// ============================================================================
`default_nettype none

interface lkv_stream_if #(
	parameter type payload_t = logic
) ();

	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);

endinterface

`default_nettype wire

>>> rtl/lkv_ram.sv
// ============================================================================
// LRU key/value cache RAM
// Generic simple dual-port RAM with one write port and a registered read.
// ============================================================================
`default_nettype none

module lkv_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write one word, read one word through the output register
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> rtl/lkv_ctrl.sv
// ============================================================================
// LRU key/value cache controller
// Sequences accept, key scan and commit for one operation at a time.
// ============================================================================
`default_nettype none

module lkv_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire lkv_pkg::ctl_sts_t sts,
	output lkv_pkg::ctl_cmd_t      ctl
);

	import lkv_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_COMMIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// Next state and commands
	always_comb begin
		state_d    = state_q;
		ctl.load   = 1'b0;
		ctl.scan   = 1'b0;
		ctl.commit = 1'b0;
		req_ready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					ctl.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				ctl.scan = 1'b1;
				if (sts.scan_done) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				// hold until the output register is free
				if (!sts.out_busy) begin
					ctl.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/lkv_dpath.sv
// ============================================================================
// LRU key/value cache datapath
// Entry RAM, valid and rank cells, scan trackers and the result register.
// ============================================================================
`default_nettype none

module lkv_dpath #(
	parameter int MAX_ENTRIES = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire lkv_pkg::ctl_cmd_t          ctl,
	output lkv_pkg::ctl_sts_t               sts,
	input  wire lkv_pkg::req_t              req_payload,
	input  wire logic [lkv_pkg::CAP_W-1:0]  cap,
	input  wire logic                       rsp_ready,
	output logic                            rsp_valid,
	output lkv_pkg::rsp_t                   rsp_payload
);

	import lkv_pkg::*;

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int RW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int EW = ((CW > CAP_W) ? CW : CAP_W) + 1;
	localparam int DW = 64;

	// Operation being worked
	logic               op_cmd_q;
	logic signed [31:0] op_key_q;
	logic signed [31:0] op_val_q;

	// Entry state
	logic          valid_q [MAX_ENTRIES];
	logic [RW-1:0] rank_q  [MAX_ENTRIES];
	logic [CW-1:0] count_q;

	// Scan pointer and read pipeline
	logic [AW:0]   issue_cnt_q;
	logic          issue_en;
	logic          rd_vld_s1;
	logic [AW-1:0] rd_idx_s1;
	logic [DW-1:0] rdata;
	logic [31:0]   rd_key;
	logic [31:0]   rd_val;

	// Scan results
	logic          hit_q;
	logic [AW-1:0] hit_idx_q;
	logic [RW-1:0] hit_rank_q;
	logic [31:0]   hit_val_q;
	logic          free_q;
	logic [AW-1:0] free_idx_q;
	logic          lru_q;
	logic [AW-1:0] lru_idx_q;
	logic [RW-1:0] lru_rank_q;
	logic [31:0]   lru_key_q;

	// Commit decision
	logic [EW-1:0] cap_e;
	logic [EW-1:0] max_e;
	logic [EW-1:0] eff_cap;
	logic          room;
	logic [AW-1:0] slot;
	logic [CW-1:0] promo_rank;
	logic          promote_en;
	logic          set_valid;
	logic          wr_en;
	rsp_t          res;

	// Result register
	logic rsp_valid_q;
	rsp_t rsp_q;

	assign issue_en = ctl.scan && (issue_cnt_q < (AW+1)'(MAX_ENTRIES));
	assign rd_key   = rdata[DW-1:32];
	assign rd_val   = rdata[31:0];

	lkv_ram #(
		.WIDTH (DW),
		.DEPTH (MAX_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (wr_en && ctl.commit),
		.waddr (slot),
		.wdata ({op_key_q, op_val_q}),
		.raddr (issue_cnt_q[AW-1:0]),
		.rdata (rdata)
	);

	// Capture the operation
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			op_cmd_q <= req_payload.cmd;
			op_key_q <= req_payload.key_in;
			op_val_q <= req_payload.value_in;
		end
	end

	// Advance the scan pointer and the read pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_cnt_q <= '0;
			rd_vld_s1   <= 1'b0;
			rd_idx_s1   <= '0;
		end else if (ctl.load) begin
			issue_cnt_q <= '0;
			rd_vld_s1   <= 1'b0;
		end else begin
			rd_vld_s1 <= issue_en;
			if (issue_en) begin
				rd_idx_s1   <= issue_cnt_q[AW-1:0];
				issue_cnt_q <= issue_cnt_q + 1'b1;
			end
		end
	end

	assign sts.scan_done = rd_vld_s1 && (rd_idx_s1 == AW'(MAX_ENTRIES - 1));

	// Track first hit, first free entry and least recent entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
			lru_q  <= 1'b0;
		end else if (ctl.load) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
			lru_q  <= 1'b0;
		end else if (rd_vld_s1) begin
			if (valid_q[rd_idx_s1] && (rd_key == op_key_q) && !hit_q) begin
				hit_q <= 1'b1;
			end
			if (!valid_q[rd_idx_s1] && !free_q) begin
				free_q <= 1'b1;
			end
			if (valid_q[rd_idx_s1]) begin
				lru_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			if (valid_q[rd_idx_s1] && (rd_key == op_key_q) && !hit_q) begin
				hit_idx_q  <= rd_idx_s1;
				hit_rank_q <= rank_q[rd_idx_s1];
				hit_val_q  <= rd_val;
			end
			if (!valid_q[rd_idx_s1] && !free_q) begin
				free_idx_q <= rd_idx_s1;
			end
			// keep the lowest index among equal highest ranks
			if (valid_q[rd_idx_s1] && (!lru_q || (rank_q[rd_idx_s1] > lru_rank_q))) begin
				lru_idx_q  <= rd_idx_s1;
				lru_rank_q <= rank_q[rd_idx_s1];
				lru_key_q  <= rd_key;
			end
		end
	end

	// Clamp the capacity to one .. MAX_ENTRIES
	assign cap_e   = EW'(cap);
	assign max_e   = EW'(MAX_ENTRIES);
	assign eff_cap = (cap_e == '0) ? EW'(1) : ((cap_e > max_e) ? max_e : cap_e);
	assign room    = EW'(count_q) < eff_cap;

	// Pick the target entry and the result
	always_comb begin
		slot            = hit_idx_q;
		promo_rank      = CW'(hit_rank_q);
		promote_en      = 1'b0;
		set_valid       = 1'b0;
		wr_en           = 1'b0;
		res.found       = 1'b0;
		res.value_out   = '0;
		res.evicted     = 1'b0;
		res.evicted_key = '0;
		priority if (op_cmd_q == CMD_GET) begin
			res.found     = hit_q;
			res.value_out = hit_q ? $signed(hit_val_q) : VALUE_MISS;
			promote_en    = hit_q;
		end else if (hit_q) begin
			res.found  = 1'b1;
			wr_en      = 1'b1;
			promote_en = 1'b1;
		end else if (room && free_q) begin
			slot       = free_idx_q;
			promo_rank = count_q;
			set_valid  = 1'b1;
			wr_en      = 1'b1;
			promote_en = 1'b1;
		end else if (lru_q) begin
			slot            = lru_idx_q;
			promo_rank      = CW'(lru_rank_q);
			res.evicted     = 1'b1;
			res.evicted_key = $signed(lru_key_q);
			wr_en           = 1'b1;
			promote_en      = 1'b1;
		end else begin
			// no valid entry and no room: fill entry zero
			slot       = '0;
			promo_rank = count_q;
			set_valid  = 1'b1;
			wr_en      = 1'b1;
			promote_en = 1'b1;
		end
	end

	// Promote the target, age the more recent entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				valid_q[i] <= 1'b0;
				rank_q[i]  <= '0;
			end
			count_q <= '0;
		end else if (ctl.commit) begin
			if (promote_en) begin
				for (int i = 0; i < MAX_ENTRIES; i++) begin
					if (AW'(i) == slot) begin
						rank_q[i] <= '0;
					end else if (valid_q[i] && (CW'(rank_q[i]) < promo_rank)) begin
						rank_q[i] <= rank_q[i] + 1'b1;
					end
				end
			end
			if (set_valid) begin
				valid_q[slot] <= 1'b1;
				count_q       <= count_q + 1'b1;
			end
		end
	end

	// Hold the result until the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			rsp_q <= res;
		end
	end

	assign sts.out_busy = rsp_valid_q && !rsp_ready;
	assign rsp_valid    = rsp_valid_q;
	assign rsp_payload  = rsp_q;

endmodule

`default_nettype wire

>>> rtl/lru_key_value_cache.sv
// ============================================================================
// LRU key/value cache
// Fully associative key/value store with least-recently-used replacement.
// ============================================================================
//
//  channel  dir  beat                               handshake
//  -------  ---  ---------------------------------  -------------------------
//  req      in   cmd, key_in, value_in              valid & ready
//  rsp      out  found, value_out, evicted, key     valid & ready
//  apb      in   capacity_in_use at byte address 0  psel & penable & pwrite
//
//  Operations run one at a time: accept, a key scan through the entry RAM
//  read port, and commit; the result register is loaded at commit, and
//  the next operation is accepted only after that commit.
//  req.ready is high only while no operation is in flight.
//  Reset clears valid bits, ranks and the count; stale RAM words stay masked.
//  A stalled rsp beat holds the commit of the next operation.
//
`default_nettype none

module lru_key_value_cache #(
	parameter int MAX_ENTRIES = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	lkv_stream_if.sink                            req,
	lkv_stream_if.source                          rsp,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [lkv_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire logic [lkv_pkg::APB_DATA_W-1:0]   pwdata,
	output logic      [lkv_pkg::APB_DATA_W-1:0]   prdata,
	output logic                                  pready
);

	import lkv_pkg::*;

	logic [CAP_W-1:0] cap_q;
	logic             reg_sel;
	ctl_cmd_t         ctl;
	ctl_sts_t         sts;
	req_t             req_beat;
	rsp_t             rsp_beat;

	assign pready   = 1'b1;
	assign reg_sel  = (paddr[APB_ADDR_W-1:2] == REG_CAPACITY);
	assign req_beat = req.payload;

	// Write the capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	// Read back the capacity register
	assign prdata = reg_sel ? APB_DATA_W'(cap_q) : '0;

	lkv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	lkv_dpath #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.sts         (sts),
		.req_payload (req_beat),
		.cap         (cap_q),
		.rsp_ready   (rsp.ready),
		.rsp_valid   (rsp.valid),
		.rsp_payload (rsp_beat)
	);

	assign rsp.payload = rsp_beat;

endmodule

`default_nettype wire

>>> rtl/lkv_checker.sv
// ============================================================================
// LRU key/value cache checker
// Port-level assertions on the cache, attached to the top level by bind.
// ============================================================================
`default_nettype none

`include "lru_key_value_cache_defines.svh"

module lkv_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_ready,
	input wire logic          rsp_valid,
	input wire logic          rsp_ready,
	input wire lkv_pkg::rsp_t rsp_payload
);

	import lkv_pkg::*;

	logic evict_beat;
	logic plain_beat;
	logic plain_ok;

	// Classify the result beat
	assign evict_beat = rsp_valid && rsp_payload.evicted;
	assign plain_beat = rsp_valid && !rsp_payload.found && !rsp_payload.evicted;
	assign plain_ok   = (rsp_payload.evicted_key == 32'sd0) &&
		((rsp_payload.value_out == VALUE_MISS) || (rsp_payload.value_out == 32'sd0));

	// One operation in flight: ready drops after each accept beat
	`LKV_ASSERT_NEXT(a_one_in_flight, clk, arst_n, req_valid && req_ready, !req_ready)

	// A result beat stays until it is taken
	`LKV_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)

	// An eviction only happens on a put of a new key
	`LKV_ASSERT_IMPLY(a_evict_miss, clk, arst_n, evict_beat, !rsp_payload.found)

	// No eviction reports a zero key, and a miss reports -1 or 0
	`LKV_ASSERT_IMPLY(a_miss_fields, clk, arst_n, plain_beat, plain_ok)

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_payload (rsp.payload)
);

`default_nettype wire
